FILE: rtl/tcf_pkg.sv
package tcf_pkg;

	// field widths
	localparam int RAW_W    = 16;
	localparam int ACCEL_W  = 17;
	localparam int RATE_W   = 18;
	localparam int ANGLE_W  = 24;
	localparam int TOTAL_W  = 24;
	localparam int CFG_W    = 16;
	localparam int IN_W     = 32;
	localparam int OUT_W    = 64;

	// shared multiplier shape
	localparam int MUL_A_W  = 36;
	localparam int MUL_B_W  = 27;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int SUM_W    = 58;

	// constant division by reciprocal: quotient estimate sits above this bit
	localparam int DIV_W    = 26;
	localparam int RECIP_SH = 26;

	// 57.2957795131 degrees per radian in Q16
	localparam int TILT_RAD_Q16 = 3754936;
	// rate: floor((512 g + 131) / 262)
	localparam int GYRO_DIV     = 262;
	localparam int GYRO_RECIP   = (1 << RECIP_SH) / GYRO_DIV;

	localparam logic [CFG_W-1:0] TIME_STEP_RST   = 16'd6554;
	localparam logic [CFG_W-1:0] GYRO_WEIGHT_RST = 16'd64225;

	localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 24'sh7FFFFF;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -24'sh800000;

	// register map
	localparam logic REG_TIME_STEP   = 1'b0;
	localparam logic REG_GYRO_WEIGHT = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_AMUL,
		ST_GMUL,
		ST_GCHK,
		ST_GFIX,
		ST_CAL,
		ST_BA_MUL,
		ST_BA_CHK,
		ST_BA_FIX,
		ST_BG_CHK,
		ST_BG_FIX,
		ST_F_DIFF,
		ST_F_RD,
		ST_F_WF,
		ST_F_ACC,
		ST_F_SUM,
		ST_F_OUT
	} state_t;

	typedef enum logic [3:0] {
		MS_NONE,
		MS_ACCEL,
		MS_G_RECIP,
		MS_G_CHK,
		MS_BA_RECIP,
		MS_B_CHK,
		MS_BG_RECIP,
		MS_RATE_DT,
		MS_RD_W,
		MS_FUSED_W,
		MS_ACC_W
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef struct packed {
		logic ready;
		mul_sel_t mul_sel;
		acc_op_t acc_op;
		logic ld_aq8;
		logic ld_q0;
		logic ld_gq8;
		logic ld_cal;
		logic ld_abias;
		logic ld_gbias;
		logic ld_diff;
		logic ld_out;
	} ctl_t;

	typedef struct packed {
		logic take;
		logic calib;
		logic cal_last;
		logic out_busy;
	} stat_t;

endpackage

FILE: rtl/tcf_mac.sv
module tcf_mac
	import tcf_pkg::*;
(
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	input  acc_op_t                   op,
	output logic signed [PROD_W-1:0]  prod,
	output logic signed [SUM_W-1:0]   sum
);

	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  sum_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
		case (op)
			ACC_LOAD: sum_q <= prod_q[SUM_W-1:0];
			ACC_ADD:  sum_q <= sum_q + {prod_q[SUM_W-17:0], 16'b0};
			default:  sum_q <= sum_q;
		endcase
	end

	assign prod = prod_q;
	assign sum  = sum_q;

endmodule

FILE: rtl/tcf_seq.sv
module tcf_seq
	import tcf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctl_t  ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (stat.take) state_d = ST_AMUL;
			ST_AMUL:   state_d = ST_GMUL;
			ST_GMUL:   state_d = ST_GCHK;
			ST_GCHK:   state_d = ST_GFIX;
			ST_GFIX:   state_d = stat.calib ? ST_CAL : ST_F_DIFF;
			ST_CAL:    state_d = stat.cal_last ? ST_BA_MUL : ST_IDLE;
			ST_BA_MUL: state_d = ST_BA_CHK;
			ST_BA_CHK: state_d = ST_BA_FIX;
			ST_BA_FIX: state_d = ST_BG_CHK;
			ST_BG_CHK: state_d = ST_BG_FIX;
			ST_BG_FIX: state_d = ST_IDLE;
			ST_F_DIFF: state_d = ST_F_RD;
			ST_F_RD:   state_d = ST_F_WF;
			ST_F_WF:   state_d = ST_F_ACC;
			ST_F_ACC:  state_d = ST_F_SUM;
			ST_F_SUM:  state_d = ST_F_OUT;
			ST_F_OUT:  if (!stat.out_busy) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.mul_sel = MS_NONE;
		ctl.acc_op = ACC_HOLD;
		unique case (state_q)
			ST_IDLE:   ctl.ready = 1'b1;
			ST_AMUL:   ctl.mul_sel = MS_ACCEL;
			ST_GMUL: begin
				ctl.mul_sel = MS_G_RECIP;
				ctl.ld_aq8 = 1'b1;
			end
			ST_GCHK: begin
				ctl.mul_sel = MS_G_CHK;
				ctl.ld_q0 = 1'b1;
			end
			ST_GFIX:   ctl.ld_gq8 = 1'b1;
			ST_CAL:    ctl.ld_cal = 1'b1;
			ST_BA_MUL: ctl.mul_sel = MS_BA_RECIP;
			ST_BA_CHK: begin
				ctl.mul_sel = MS_B_CHK;
				ctl.ld_q0 = 1'b1;
			end
			ST_BA_FIX: begin
				ctl.mul_sel = MS_BG_RECIP;
				ctl.ld_abias = 1'b1;
			end
			ST_BG_CHK: begin
				ctl.mul_sel = MS_B_CHK;
				ctl.ld_q0 = 1'b1;
			end
			ST_BG_FIX: ctl.ld_gbias = 1'b1;
			ST_F_DIFF: begin
				ctl.mul_sel = MS_RATE_DT;
				ctl.ld_diff = 1'b1;
			end
			ST_F_RD:   ctl.mul_sel = MS_RD_W;
			ST_F_WF: begin
				ctl.mul_sel = MS_FUSED_W;
				ctl.acc_op = ACC_LOAD;
			end
			ST_F_ACC: begin
				ctl.mul_sel = MS_ACC_W;
				ctl.acc_op = ACC_ADD;
			end
			ST_F_SUM:  ctl.acc_op = ACC_ADD;
			ST_F_OUT:  ctl.ld_out = !stat.out_busy;
			default:   ctl.ready = 1'b0;
		endcase
	end

endmodule

FILE: rtl/tilt_complementary_filter.sv
// channel  | dir | tdata fields, lowest bit first                         | tuser/tlast
// s_axis   | in  | accel_sample[15:0], gyro_sample[31:16]                 | none
// m_axis   | out | accel_angle[16:0], gyro_rate[34:17], tilt_angle[58:35] | none
// cfg      | in  | cfg_index 0 time_step, 1 gyro_weight, cfg_data[15:0]   | write only
//
// the arithmetic steps share one registered 36x27 multiplier plus accumulator,
// so they run one after another in sequencer order:
// calibration item: scale accel and gyro, add to the sums; the last one also divides out the biases
// filter item: scale, remove biases, weight and sum; result valid and ready again in the same cycle
// reset clears config to defaults, calibration count, sums, biases and angle
// a stalled result holds the sequencer in its last step; no request is lost
module tilt_complementary_filter
	import tcf_pkg::*;
#(
	parameter int CAL_SAMPLES = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	// accel_sample[15:0], gyro_sample[31:16]
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	// accel_angle[16:0], gyro_rate[34:17], tilt_angle[58:35], zero fill above
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
	// bias = floor((2 total + n) / 2n)
	localparam int DIV_B   = 2 * CAL_SAMPLES;
	localparam int RECIP_B = (1 << RECIP_SH) / DIV_B;

	// floor division by a constant: fold the sign, then reciprocal estimate
	function automatic logic [DIV_W:0] div_prep(input logic signed [DIV_W-1:0] x,
		input logic [DIV_W-1:0] dm1);
		logic [DIV_W-1:0] m;
		begin
			m = x[DIV_W-1] ? (dm1 - x) : x;
			return {x[DIV_W-1], m};
		end
	endfunction

	// one correction step: estimate is exact or one short
	function automatic logic signed [DIV_W:0] div_fix(input logic [DIV_W:0] prep,
		input logic [DIV_W-1:0] q0, input logic [DIV_W:0] qd, input logic [DIV_W:0] d);
		logic [DIV_W:0] r;
		logic [DIV_W:0] q;
		begin
			r = {1'b0, prep[DIV_W-1:0]} - qd;
			q = {1'b0, q0} + {{DIV_W{1'b0}}, (r >= d)};
			return prep[DIV_W] ? -q : q;
		end
	endfunction

	ctl_t  ctl;
	stat_t stat;

	// config
	logic [CFG_W-1:0] dt_q;
	logic [CFG_W-1:0] w_q;

	// filter state
	logic [CNT_W-1:0]          cnt_q;
	logic signed [TOTAL_W-1:0] atot_q;
	logic signed [TOTAL_W-1:0] gtot_q;
	logic signed [ACCEL_W-1:0] abias_q;
	logic signed [RATE_W-1:0]  gbias_q;
	logic signed [ANGLE_W-1:0] fused_q;

	// per item working registers
	logic signed [RAW_W-1:0]   a_raw_q;
	logic signed [RAW_W-1:0]   g_raw_q;
	logic signed [RAW_W-1:0]   a_q8_q;
	logic signed [RATE_W-1:0]  g_q8_q;
	logic [DIV_W-1:0]          q0_q;
	logic signed [ACCEL_W-1:0] acc_q;
	logic signed [RATE_W-1:0]  rate_q;

	// output stage
	logic               out_vld_q;
	logic [OUT_W-1:0]   out_data_q;

	// shared multiplier
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [SUM_W-1:0]   sum;

	logic signed [DIV_W-1:0]   g_x;
	logic signed [DIV_W-1:0]   ba_x;
	logic signed [DIV_W-1:0]   bg_x;
	logic [DIV_W:0]            g_prep;
	logic [DIV_W:0]            ba_prep;
	logic [DIV_W:0]            bg_prep;
	logic signed [DIV_W:0]     g_div;
	logic signed [DIV_W:0]     ba_div;
	logic signed [DIV_W:0]     bg_div;
	logic signed [ACCEL_W-1:0] acc_w;
	logic signed [RATE_W-1:0]  rate_w;
	logic [ACCEL_W-1:0]        w_rest;
	logic signed [SUM_W-1:0]   rnd;
	logic signed [SUM_W-33:0]  ang_full;
	logic signed [ANGLE_W-1:0] ang_sat;
	logic signed [37:0]        a_rnd;

	tcf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	tcf_mac u_mac (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.op   (ctl.acc_op),
		.prod (prod),
		.sum  (sum)
	);

	assign s_tready = ctl.ready;

	assign stat.take     = s_tvalid && ctl.ready;
	assign stat.calib    = cnt_q != CNT_W'(CAL_SAMPLES);
	assign stat.cal_last = cnt_q == CNT_W'(CAL_SAMPLES - 1);
	assign stat.out_busy = out_vld_q && !m_tready;

	// divider operands, all from registers that hold through the sequence
	assign g_x  = ($signed({{(DIV_W-RAW_W){g_raw_q[RAW_W-1]}}, g_raw_q}) <<< 9)
		+ DIV_W'(131);
	assign ba_x = $signed({atot_q[TOTAL_W-1], atot_q, 1'b0}) + DIV_W'(CAL_SAMPLES);
	assign bg_x = $signed({gtot_q[TOTAL_W-1], gtot_q, 1'b0}) + DIV_W'(CAL_SAMPLES);

	assign g_prep  = div_prep(g_x, DIV_W'(GYRO_DIV - 1));
	assign ba_prep = div_prep(ba_x, DIV_W'(DIV_B - 1));
	assign bg_prep = div_prep(bg_x, DIV_W'(DIV_B - 1));

	assign g_div  = div_fix(g_prep, q0_q, prod[DIV_W:0], (DIV_W+1)'(GYRO_DIV));
	assign ba_div = div_fix(ba_prep, q0_q, prod[DIV_W:0], (DIV_W+1)'(DIV_B));
	assign bg_div = div_fix(bg_prep, q0_q, prod[DIV_W:0], (DIV_W+1)'(DIV_B));

	// bias-corrected values
	assign acc_w  = {a_q8_q[RAW_W-1], a_q8_q} - abias_q;
	assign rate_w = g_q8_q - gbias_q;
	assign w_rest = ACCEL_W'(65536) - {1'b0, w_q};

	// accel tilt: round half up of raw * rad_q16 / 2^22
	assign a_rnd = prod[37:0] + 38'sd2097152;

	// fused angle: round half up at 2^32, then clamp
	assign rnd      = sum + (SUM_W'(1) <<< 31);
	assign ang_full = rnd[SUM_W-1:32];
	always_comb begin
		if (ang_full > (SUM_W-32)'(ANGLE_MAX)) begin
			ang_sat = ANGLE_MAX;
		end else if (ang_full < (SUM_W-32)'(ANGLE_MIN)) begin
			ang_sat = ANGLE_MIN;
		end else begin
			ang_sat = ang_full[ANGLE_W-1:0];
		end
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctl.mul_sel)
			MS_ACCEL: begin
				mul_a = MUL_A_W'(TILT_RAD_Q16);
				mul_b = MUL_B_W'(a_raw_q);
			end
			MS_G_RECIP: begin
				mul_a = MUL_A_W'(g_prep[DIV_W-1:0]);
				mul_b = MUL_B_W'(GYRO_RECIP);
			end
			MS_G_CHK: begin
				mul_a = MUL_A_W'(prod[RECIP_SH+DIV_W-1:RECIP_SH]);
				mul_b = MUL_B_W'(GYRO_DIV);
			end
			MS_BA_RECIP: begin
				mul_a = MUL_A_W'(ba_prep[DIV_W-1:0]);
				mul_b = MUL_B_W'(RECIP_B);
			end
			MS_B_CHK: begin
				mul_a = MUL_A_W'(prod[RECIP_SH+DIV_W-1:RECIP_SH]);
				mul_b = MUL_B_W'(DIV_B);
			end
			MS_BG_RECIP: begin
				mul_a = MUL_A_W'(bg_prep[DIV_W-1:0]);
				mul_b = MUL_B_W'(RECIP_B);
			end
			MS_RATE_DT: begin
				mul_a = MUL_A_W'(rate_w);
				mul_b = MUL_B_W'({1'b0, dt_q});
			end
			MS_RD_W: begin
				// rate * dt fits well inside the a operand
				mul_a = prod[MUL_A_W-1:0];
				mul_b = MUL_B_W'({1'b0, w_q});
			end
			MS_FUSED_W: begin
				mul_a = MUL_A_W'(fused_q);
				mul_b = MUL_B_W'({1'b0, w_q});
			end
			MS_ACC_W: begin
				mul_a = MUL_A_W'(acc_q);
				mul_b = MUL_B_W'({1'b0, w_rest});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= TIME_STEP_RST;
			w_q  <= GYRO_WEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIME_STEP:   dt_q <= cfg_data;
				REG_GYRO_WEIGHT: w_q  <= cfg_data;
				default:         dt_q <= dt_q;
			endcase
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			atot_q  <= '0;
			gtot_q  <= '0;
			abias_q <= '0;
			gbias_q <= '0;
			fused_q <= '0;
		end else begin
			if (ctl.ld_cal) begin
				cnt_q  <= cnt_q + CNT_W'(1);
				atot_q <= atot_q + TOTAL_W'(a_q8_q);
				gtot_q <= gtot_q + TOTAL_W'(g_q8_q);
			end
			if (ctl.ld_abias) abias_q <= ba_div[ACCEL_W-1:0];
			if (ctl.ld_gbias) gbias_q <= bg_div[RATE_W-1:0];
			if (ctl.ld_out)   fused_q <= ang_sat;
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (stat.take) begin
			a_raw_q <= s_tdata[RAW_W-1:0];
			g_raw_q <= s_tdata[2*RAW_W-1:RAW_W];
		end
		if (ctl.ld_aq8) a_q8_q <= a_rnd[37:22];
		if (ctl.ld_q0)  q0_q   <= prod[RECIP_SH+DIV_W-1:RECIP_SH];
		if (ctl.ld_gq8) g_q8_q <= g_div[RATE_W-1:0];
		if (ctl.ld_diff) begin
			acc_q  <= acc_w;
			rate_q <= rate_w;
		end
		if (ctl.ld_out) begin
			out_data_q <= {{(OUT_W-ACCEL_W-RATE_W-ANGLE_W){1'b0}}, ang_sat, rate_q, acc_q};
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.ld_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// a request occupies the sequencer, so ready drops after it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("ready did not drop after a request");

	// no result while the biases are still being gathered
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ld_out |-> !stat.calib)
		else $error("result produced during calibration");

	// a new result never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ld_out |-> !(out_vld_q && !m_tready))
		else $error("pending result overwritten");

	// the emitted angle is the stored angle
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ld_out |=> (m_tdata[ACCEL_W+RATE_W+ANGLE_W-1:ACCEL_W+RATE_W] == fused_q))
		else $error("output angle differs from filter state");

endmodule
